@@ hdl/contiguous_page_allocator_core_assert.svh @@
// assertion macros for the contiguous page allocator core
// included by the datapath; needs clk and rst_n in the including scope
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define CPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define CPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPA_ASSERT(lbl, prop, msg)
`define CPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/cpa_pkg.sv @@
// shared types, constants and codes of the contiguous page allocator
// used by cpa_ctrl, cpa_dp and contiguous_page_allocator_core; no dependencies
package cpa_pkg;

    // store geometry
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);

    // field widths
    localparam int ADDR_W     = 32;
    localparam int BASE_W     = 20;
    localparam int COUNT_W    = 11;
    localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // reset values of the registers
    localparam logic [BASE_W-1:0]  BASE_PAGE_RST    = '0;
    localparam logic [COUNT_W-1:0] USABLE_PAGES_RST = COUNT_W'(1024);

    // page descriptor bits
    localparam int FLAG_W = 2;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_PAGE    = 1'b0,
        REG_USABLE_PAGES = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [COUNT_W-1:0]  page_count;
        logic [ADDR_W-1:0]   address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        logic                success;
    } rsp_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_LOAD   = 3'd2,
        OP_START  = 3'd3,
        OP_SCAN   = 3'd4,
        OP_MARK   = 3'd5,
        OP_WALK   = 3'd6,
        OP_RESULT = 3'd7
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic alloc_ok;
        logic free_ok;
        logic found;
        logic scan_end;
        logic mark_done;
        logic walk_end;
        logic rsp_free;
    } stat_t;

endpackage

@@ hdl/cpa_ctrl.sv @@
// controller state machine of the contiguous page allocator
// depends on cpa_pkg; drives datapath commands from datapath status
module cpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cpa_pkg::stat_t stat,
    output cpa_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_MARK   = 7'b0010000,
        ST_WALK   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // items are taken only between requests
    assign req_stall = (state_reg != ST_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = cpa_pkg::OP_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = cpa_pkg::OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = cpa_pkg::OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.op = cpa_pkg::OP_START;
                if (stat.is_free)
                begin
                    state_next = stat.free_ok ? ST_WALK : ST_RESULT;
                end
                else
                begin
                    state_next = stat.alloc_ok ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.op = cpa_pkg::OP_SCAN;
                if (stat.found)
                begin
                    state_next = ST_MARK;
                end
                else if (stat.scan_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_MARK:
            begin
                cmd.op = cpa_pkg::OP_MARK;
                if (stat.mark_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                cmd.op = cpa_pkg::OP_WALK;
                if (stat.walk_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.rsp_free)
                begin
                    cmd.op     = cpa_pkg::OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, clearing pass first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/cpa_dp.sv @@
// datapath of the contiguous page allocator: registers, descriptor memory,
// scan and walk pointers, result register; depends on cpa_pkg and the assert header
`include "contiguous_page_allocator_core_assert.svh"

module cpa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  cpa_pkg::cfg_reg_t                 cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cpa_pkg::req_t                     req,
    input  logic                              rsp_stall,
    output logic                              rsp_valid,
    output cpa_pkg::rsp_t                     rsp,
    input  cpa_pkg::cmd_t                     cmd,
    output cpa_pkg::stat_t                    stat
);

    // descriptor store
    logic [cpa_pkg::FLAG_W-1:0] mem [cpa_pkg::MAX_PAGES];
    logic [cpa_pkg::FLAG_W-1:0] rd_data_reg;

    // configuration
    logic [cpa_pkg::BASE_W-1:0]  base_page_reg;
    logic [cpa_pkg::COUNT_W-1:0] usable_reg;

    // request and walk state
    cpa_pkg::req_t              req_reg, req_next;
    logic [cpa_pkg::CNT_W-1:0]  ptr_reg, ptr_next;
    logic                       ev_valid_reg, ev_valid_next;
    logic [cpa_pkg::IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic [cpa_pkg::CNT_W-1:0]  run_reg, run_next;
    logic [cpa_pkg::IDX_W-1:0]  mark_ptr_reg, mark_ptr_next;
    logic [cpa_pkg::IDX_W-1:0]  mark_end_reg, mark_end_next;

    // result
    logic                        res_ok_reg, res_ok_next;
    logic [cpa_pkg::ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    cpa_pkg::rsp_t               rsp_reg, rsp_next;

    // combinational helpers
    logic [cpa_pkg::CNT_W-1:0]                   eff_pages;
    logic [cpa_pkg::ADDR_W-1:0]                  heap_base;
    logic [cpa_pkg::ADDR_W:0]                    diff;
    logic [cpa_pkg::ADDR_W-cpa_pkg::PAGE_SHIFT-1:0] page_off;
    logic                                        in_range;
    logic                                        free_ok;
    logic [cpa_pkg::IDX_W-1:0]                   free_idx;
    logic                                        alloc_ok;
    logic                                        rd_taken;
    logic                                        rd_last;
    logic [cpa_pkg::CNT_W-1:0]                   run_inc;
    logic                                        hit;
    logic [cpa_pkg::IDX_W-1:0]                   hit_start;
    logic [cpa_pkg::ADDR_W-1:0]                  alloc_addr;
    logic                                        can_issue;
    logic                                        walk_stop;

    // memory port controls
    logic                        mem_we;
    logic [cpa_pkg::IDX_W-1:0]   mem_wa;
    logic [cpa_pkg::FLAG_W-1:0]  mem_wd;
    logic                        mem_re;
    logic [cpa_pkg::IDX_W-1:0]   mem_ra;

    // page count limited to the store depth
    assign eff_pages = (cpa_pkg::CMP_W'(usable_reg) > cpa_pkg::CMP_W'(cpa_pkg::MAX_PAGES)) ?
                       cpa_pkg::CNT_W'(cpa_pkg::MAX_PAGES) : cpa_pkg::CNT_W'(usable_reg);

    // free bounds: address - heap base, then page offset against page count
    assign heap_base = cpa_pkg::ADDR_W'({base_page_reg, {cpa_pkg::PAGE_SHIFT{1'b0}}});
    assign diff      = {1'b0, req_reg.address} - {1'b0, heap_base};
    assign page_off  = diff[cpa_pkg::ADDR_W-1:cpa_pkg::PAGE_SHIFT];
    assign in_range  = !diff[cpa_pkg::ADDR_W] &&
                       (page_off < (cpa_pkg::ADDR_W - cpa_pkg::PAGE_SHIFT)'(eff_pages));
    assign free_ok   = (req_reg.address != '0) && in_range;
    assign free_idx  = diff[cpa_pkg::PAGE_SHIFT+cpa_pkg::IDX_W-1:cpa_pkg::PAGE_SHIFT];

    // alloc bounds
    assign alloc_ok = (req_reg.page_count != '0) &&
                      (cpa_pkg::CMP_W'(req_reg.page_count) <= cpa_pkg::CMP_W'(eff_pages));

    // descriptor read back in the cycle after issue
    assign rd_taken = (rd_data_reg & cpa_pkg::FLAG_TAKEN) != '0;
    assign rd_last  = (rd_data_reg & cpa_pkg::FLAG_LAST) != '0;

    // first-fit run tracking
    assign run_inc    = run_reg + cpa_pkg::CNT_W'(1);
    assign hit        = ev_valid_reg && !rd_taken &&
                        (cpa_pkg::CMP_W'(run_inc) == cpa_pkg::CMP_W'(req_reg.page_count));
    assign hit_start  = ev_idx_reg - cpa_pkg::IDX_W'(run_reg);
    assign alloc_addr = cpa_pkg::ADDR_W'({cpa_pkg::ADDR_W'(base_page_reg) +
                                          cpa_pkg::ADDR_W'(hit_start),
                                          {cpa_pkg::PAGE_SHIFT{1'b0}}});

    assign can_issue = ptr_reg < eff_pages;
    assign walk_stop = ev_valid_reg && (!rd_taken || rd_last);

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ptr_reg[cpa_pkg::IDX_W-1:0];
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = ptr_reg[cpa_pkg::IDX_W-1:0];
        case (cmd.op)
            cpa_pkg::OP_CLEAR:
            begin
                mem_we = 1'b1;
            end
            cpa_pkg::OP_SCAN:
            begin
                mem_re = can_issue && !hit;
            end
            cpa_pkg::OP_MARK:
            begin
                mem_we = 1'b1;
                mem_wa = mark_ptr_reg;
                mem_wd = (mark_ptr_reg == mark_end_reg) ?
                         (cpa_pkg::FLAG_TAKEN | cpa_pkg::FLAG_LAST) : cpa_pkg::FLAG_TAKEN;
            end
            cpa_pkg::OP_WALK:
            begin
                mem_re = can_issue && !walk_stop;
                mem_we = ev_valid_reg && rd_taken;
                mem_wa = ev_idx_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // descriptor memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // next values of the working registers
    always_comb
    begin
        req_next       = req_reg;
        ptr_next       = ptr_reg;
        ev_valid_next  = 1'b0;
        ev_idx_next    = ev_idx_reg;
        run_next       = run_reg;
        mark_ptr_next  = mark_ptr_reg;
        mark_end_next  = mark_end_reg;
        res_ok_next    = res_ok_reg;
        res_addr_next  = res_addr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (cmd.op)
            cpa_pkg::OP_CLEAR:
            begin
                ptr_next = ptr_reg + cpa_pkg::CNT_W'(1);
            end
            cpa_pkg::OP_LOAD:
            begin
                req_next = req;
            end
            cpa_pkg::OP_START:
            begin
                ptr_next      = (req_reg.mode == cpa_pkg::MODE_FREE) ?
                                cpa_pkg::CNT_W'(free_idx) : '0;
                run_next      = '0;
                res_ok_next   = (req_reg.mode == cpa_pkg::MODE_FREE) && free_ok;
                res_addr_next = '0;
            end
            cpa_pkg::OP_SCAN:
            begin
                if (mem_re)
                begin
                    ptr_next      = ptr_reg + cpa_pkg::CNT_W'(1);
                    ev_valid_next = 1'b1;
                    ev_idx_next   = ptr_reg[cpa_pkg::IDX_W-1:0];
                end
                if (ev_valid_reg)
                begin
                    run_next = rd_taken ? '0 : run_inc;
                end
                if (hit)
                begin
                    res_ok_next   = 1'b1;
                    res_addr_next = alloc_addr;
                    mark_ptr_next = hit_start;
                    mark_end_next = ev_idx_reg;
                end
            end
            cpa_pkg::OP_MARK:
            begin
                mark_ptr_next = mark_ptr_reg + cpa_pkg::IDX_W'(1);
            end
            cpa_pkg::OP_WALK:
            begin
                if (mem_re)
                begin
                    ptr_next      = ptr_reg + cpa_pkg::CNT_W'(1);
                    ev_valid_next = 1'b1;
                    ev_idx_next   = ptr_reg[cpa_pkg::IDX_W-1:0];
                end
            end
            cpa_pkg::OP_RESULT:
            begin
                rsp_next.block_address = res_addr_reg;
                rsp_next.success       = res_ok_reg;
                rsp_valid_next         = 1'b1;
            end
            default:
            begin
                ev_valid_next = 1'b0;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg <= cpa_pkg::BASE_PAGE_RST;
            usable_reg    <= cpa_pkg::USABLE_PAGES_RST;
            ptr_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            run_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cpa_pkg::REG_BASE_PAGE:
                    begin
                        base_page_reg <= cfg_data[cpa_pkg::BASE_W-1:0];
                    end
                    cpa_pkg::REG_USABLE_PAGES:
                    begin
                        usable_reg <= cfg_data[cpa_pkg::COUNT_W-1:0];
                    end
                    default:
                    begin
                        base_page_reg <= base_page_reg;
                    end
                endcase
            end
            ptr_reg       <= ptr_next;
            ev_valid_reg  <= ev_valid_next;
            run_reg       <= run_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ev_idx_reg   <= ev_idx_next;
        mark_ptr_reg <= mark_ptr_next;
        mark_end_reg <= mark_end_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        rsp_reg      <= rsp_next;
    end

    // status to the controller
    always_comb
    begin
        stat.clear_done = ptr_reg[cpa_pkg::IDX_W-1:0] == cpa_pkg::IDX_W'(cpa_pkg::MAX_PAGES - 1);
        stat.is_free    = req_reg.mode == cpa_pkg::MODE_FREE;
        stat.alloc_ok   = alloc_ok;
        stat.free_ok    = free_ok;
        stat.found      = hit;
        stat.scan_end   = !ev_valid_reg && !can_issue;
        stat.mark_done  = mark_ptr_reg == mark_end_reg;
        stat.walk_end   = walk_stop || (!ev_valid_reg && !can_issue);
        stat.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `CPA_ASSERT(a_mark_in_block, (cmd.op == cpa_pkg::OP_MARK) |-> (mark_ptr_reg <= mark_end_reg), "mark pointer passed the block end")
    `CPA_ASSERT(a_walk_in_range, (cmd.op == cpa_pkg::OP_WALK && mem_we) |-> (cpa_pkg::CNT_W'(ev_idx_reg) < eff_pages), "free walk cleared a page past the usable range")
    `CPA_ASSERT(a_rsp_from_result, $rose(rsp_valid_reg) |-> $past(cmd.op == cpa_pkg::OP_RESULT), "result shown without a result command")
    `CPA_ASSERT_ALWAYS(a_write_source, mem_we |-> (cmd.op == cpa_pkg::OP_CLEAR || cmd.op == cpa_pkg::OP_MARK || cmd.op == cpa_pkg::OP_WALK), "descriptor write outside clear mark or walk")

endmodule

@@ hdl/contiguous_page_allocator_core.sv @@
// First-fit contiguous page allocator with a 1024-entry descriptor memory
// (taken and last bits per page). After reset a clearing pass writes every
// descriptor, during which no item is taken; configuration writes are
// taken at any time. Each item is handled alone and one descriptor is
// visited per cycle through the single memory read port: an allocation
// of N pages scans up to the end of the first free run (at most the
// usable page count) and, if one is found, then marks its N pages; a
// rejected item goes straight to the result; a free walks the pages of
// its block. The result waits in an output register, and the next item
// is taken while it is held.
// depends on cpa_pkg, cpa_ctrl and cpa_dp
module contiguous_page_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  cpa_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output cpa_pkg::rsp_t                   rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  cpa_pkg::cfg_reg_t               cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cpa_pkg::cmd_t  cmd;
    cpa_pkg::stat_t stat;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // controller
    cpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    cpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ tb/cpa_reply_checker.sv @@
// reply checker for the contiguous page allocator: mirrors the descriptor store
// and registers, predicts each reply and compares it; depends on cpa_pkg
`timescale 1ns / 1ps

module cpa_reply_checker
    import cpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_count,
    output int                    success_count
);

    // mirrored state and registers
    logic [FLAG_W-1:0]  page_flags [MAX_PAGES];
    logic [BASE_W-1:0]  base_page;
    logic [COUNT_W-1:0] usable_pages;

    // replies still owed by the block, oldest first
    rsp_t replies_owed [$];
    rsp_t oldest;

    // first-fit allocation or block release on the mirrored store
    function automatic rsp_t serve_request(input req_t r);
        rsp_t              res;
        int unsigned       limit;
        int unsigned       run;
        int unsigned       first;
        int unsigned       idx;
        logic [ADDR_W-1:0] heap_lo;
        logic [ADDR_W:0]   heap_hi;
        logic [FLAG_W-1:0] f;
        bit                found;
        res     = '0;
        limit   = (usable_pages > MAX_PAGES) ? MAX_PAGES : usable_pages;
        heap_lo = ADDR_W'(base_page) << PAGE_SHIFT;
        // heap end is computed one bit wider so it does not wrap
        heap_hi = {1'b0, heap_lo} + ((ADDR_W+1)'(limit) << PAGE_SHIFT);
        if (r.mode == MODE_ALLOC)
        begin
            run   = 0;
            found = 1'b0;
            if (r.page_count != 0 && r.page_count <= limit)
            begin
                for (idx = 0; idx < limit && !found; idx++)
                begin
                    if ((page_flags[idx] & FLAG_TAKEN) != '0)
                    begin
                        run = 0;
                    end
                    else
                    begin
                        run++;
                        if (run == r.page_count)
                        begin
                            first = idx + 1 - run;
                            for (int k = first; k <= idx; k++)
                            begin
                                page_flags[k] |= FLAG_TAKEN;
                            end
                            page_flags[idx] |= FLAG_LAST;
                            res.block_address = heap_lo + (ADDR_W'(first) << PAGE_SHIFT);
                            res.success       = 1'b1;
                            found             = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            if (r.address != '0 && r.address >= heap_lo && {1'b0, r.address} < heap_hi)
            begin
                res.success = 1'b1;
                idx = (r.address - heap_lo) >> PAGE_SHIFT;
                // release pages up to the block's last page, a free page or the table end
                while (idx < limit)
                begin
                    f = page_flags[idx];
                    if ((f & FLAG_TAKEN) == '0)
                        break;
                    page_flags[idx] = '0;
                    if ((f & FLAG_LAST) != '0)
                        break;
                    idx++;
                end
            end
        end
        return res;
    endfunction

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (page_flags[i])
                page_flags[i] = '0;
            base_page     = BASE_PAGE_RST;
            usable_pages  = USABLE_PAGES_RST;
            replies_owed.delete();
            fail_count    = 0;
            pending_count = 0;
            success_count = 0;
        end
        else
        begin
            // compare a delivered reply with the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_owed.size() == 0)
                begin
                    $error("reply with none owed: block_address %h success %b",
                           rsp.block_address, rsp.success);
                    fail_count++;
                end
                else
                begin
                    oldest = replies_owed.pop_front();
                    if (rsp.block_address !== oldest.block_address)
                    begin
                        $error("block_address: expected %h, got %h",
                               oldest.block_address, rsp.block_address);
                        fail_count++;
                    end
                    if (rsp.success !== oldest.success)
                    begin
                        $error("success: expected %b, got %b", oldest.success, rsp.success);
                        fail_count++;
                    end
                    if (rsp.success === 1'b1)
                        success_count++;
                end
            end

            // predict the reply of an accepted item
            if (req_valid && !req_stall)
                replies_owed.push_back(serve_request(req));

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_PAGE:    base_page    = cfg_data[BASE_W-1:0];
                    REG_USABLE_PAGES: usable_pages = cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end

            pending_count = replies_owed.size();
        end
    end

endmodule

@@ tb/contiguous_page_allocator_core_tb.sv @@
// top of the contiguous page allocator testbench: clock, reset, item and
// register stimulus, output back-pressure and verdict; needs cpa_pkg, the core and cpa_reply_checker
`timescale 1ns / 1ps

module contiguous_page_allocator_core_tb;
    import cpa_pkg::*;

    localparam int          HOLD_CYCLES  = 400;
    localparam int          LIMIT_CYCLES = 5_000_000;
    localparam logic [31:0] HEAP_MID     = 32'h0001_0000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int success_count;

    // stimulus bookkeeping
    bit idle_on;
    bit hold_request;
    int hold_left;
    int stall_left;
    int cycles = 0;
    int n_alloc;
    int n_free;
    int n_settings;

    contiguous_page_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cpa_reply_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .success_count (success_count)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // reply side: one long hold on request, otherwise short random stall bursts while idle_on is set
    initial
    begin
        rsp_stall  = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // offer one item, with an optional gap first; returns on a falling edge
    task automatic send_item(input req_t r);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.mode == MODE_ALLOC)
            n_alloc++;
        else
            n_free++;
        @(negedge clk);
    endtask

    task automatic issue(input mode_t m, input int unsigned pages, input logic [31:0] addr);
        req_t r;
        r.mode       = m;
        r.page_count = COUNT_W'(pages);
        r.address    = addr;
        send_item(r);
    endtask

    // mostly small allocations and frees inside the heap, some noise
    task automatic issue_random(input logic [BASE_W-1:0] base, input int unsigned eff);
        req_t        r;
        int unsigned pick;
        int unsigned top_run;
        logic [31:0] heap_lo;
        pick         = $urandom_range(0, 99);
        heap_lo      = 32'(base) << PAGE_SHIFT;
        top_run      = (eff > 6) ? eff / 6 : 1;
        r.mode       = MODE_ALLOC;
        r.page_count = COUNT_W'($urandom);
        r.address    = $urandom;
        if (pick < 45)
        begin
            if ($urandom_range(0, 39) == 0)
                r.page_count = COUNT_W'(eff);
            else
                r.page_count = COUNT_W'($urandom_range(1, top_run));
        end
        else if (pick < 85)
        begin
            r.mode    = MODE_FREE;
            r.address = heap_lo
                      + (32'($urandom_range(0, (eff > 0) ? eff - 1 : 0)) << PAGE_SHIFT);
            if ($urandom_range(0, 3) == 0)
                r.address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        end
        else
        begin
            r.mode = mode_t'($urandom_range(0, 1));
        end
        send_item(r);
    endtask

    // stop offering and wait until every reply has come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // write both registers back to back, random bits above each field
    task automatic apply_setting(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] pages);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_BASE_PAGE;
        cfg_data  <= (CFG_DATA_W'($urandom) << BASE_W) | CFG_DATA_W'(base);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= REG_USABLE_PAGES;
        cfg_data  <= (CFG_DATA_W'($urandom) << COUNT_W) | CFG_DATA_W'(pages);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] pages,
                             input int items, input bit idle, input bit long_hold);
        int unsigned eff;
        eff = (pages > MAX_PAGES) ? MAX_PAGES : pages;
        apply_setting(base, pages);
        idle_on = idle;
        if (long_hold)
            hold_request = 1'b1;
        repeat (items)
            issue_random(base, eff);
    endtask

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BASE_PAGE;
        cfg_data     = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        n_alloc      = 0;
        n_free       = 0;
        n_settings   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: heap at 0, all 1024 pages
        issue(MODE_ALLOC, 0, $urandom);
        issue(MODE_ALLOC, 2047, $urandom);
        issue(MODE_ALLOC, 1, $urandom);
        issue(MODE_ALLOC, 3, $urandom);
        issue(MODE_FREE, $urandom, 32'h0000_0000);
        issue(MODE_FREE, $urandom, 32'h0000_1123);
        issue(MODE_FREE, $urandom, 32'h0000_1000);
        issue(MODE_FREE, $urandom, 32'h0040_0000);
        issue(MODE_ALLOC, 1024, $urandom);
        issue(MODE_ALLOC, 1023, $urandom);
        issue(MODE_ALLOC, 1, $urandom);
        issue(MODE_FREE, 0, 32'h0000_1000);
        issue(MODE_ALLOC, 24, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 990, 32'h0000_0000);
        issue(MODE_FREE, 2047, 32'h0000_5000);

        // shrink the table below a live block so a release walks off its end
        apply_setting(20'h00010, 11'd1010);
        issue(MODE_FREE, 0, HEAP_MID + (32'd1005 << PAGE_SHIFT));
        issue(MODE_FREE, 0, HEAP_MID + (32'd1 << PAGE_SHIFT));
        issue(MODE_FREE, 0, HEAP_MID - 32'd1);
        issue(MODE_FREE, 0, HEAP_MID + (32'd1010 << PAGE_SHIFT));
        issue(MODE_ALLOC, 1011, 0);

        // heap at the top of the address space, addresses wrap
        apply_setting(20'hFFFFF, 11'd16);
        issue(MODE_ALLOC, 2, $urandom);
        issue(MODE_FREE, 0, 32'h0000_0000);
        issue(MODE_FREE, 0, 32'hFFFF_FFFF);
        issue(MODE_ALLOC, 1, $urandom);
        repeat (40)
            issue_random(20'hFFFFF, 16);

        // random phases over a range of settings
        run_phase(20'($urandom), 11'd32, 150, 1'b1, 1'b0);
        run_phase(20'($urandom), 11'd8, 100, 1'b1, 1'b1);
        run_phase(20'($urandom), 11'd1, 30, 1'b1, 1'b0);
        run_phase(20'h00000, 11'd0, 15, 1'b1, 1'b0);
        run_phase(20'($urandom), 11'd2047, 60, 1'b1, 1'b0);
        run_phase(20'($urandom), 11'd128, 170, 1'b0, 1'b0);

        // drain and let the block settle
        wait_idle();
        repeat (20) @(negedge clk);

        $display("covered %0d requests: %0d allocations, %0d frees, %0d register settings",
                 n_alloc + n_free, n_alloc, n_free, n_settings);
        $display("%0d replies reported success; one output hold of %0d cycles",
                 success_count, HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
